@@ design/rzsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rzsa_pkg: shared types and constants for the rotozoom source address block
// Register indexes, mode words, datapath widths and the config/mode structs.
// ----------------------------------------------------------------------------
package rzsa_pkg;

  // Defaults for the top level parameters
  localparam int MAP_SIZE_DEF        = 2048;
  localparam int DEST_COORD_BITS_DEF = 9;

  // Fixed datapath widths
  localparam int REG_W   = 16;  // config register width
  localparam int IDX_W   = 3;   // config index width
  localparam int ACC_W   = 24;  // accumulator bits kept (coordinate is [23:8])
  localparam int CRD_LSB = 8;
  localparam int CRD_W   = 16;
  localparam int SRC_W   = 11;  // source coordinate output width

  // Fixed constants
  localparam int COL_OFFSET     = 38;
  localparam int SMALL_MAP_SIZE = 256;

  // Mode words
  localparam logic [REG_W-1:0] MODE_RESET        = 16'h4400;
  localparam logic [REG_W-1:0] MODE_NOWRAP_A     = 16'h4488;
  localparam logic [REG_W-1:0] MODE_NOWRAP_B     = 16'h44cc;
  localparam logic [REG_W-1:0] MODE_NOWRAP_SMALL = 16'h44ee;

  // Config register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_INC_XX     = 3'd0,
    CFG_INC_XY     = 3'd1,
    CFG_INC_YX     = 3'd2,
    CFG_INC_YY     = 3'd3,
    CFG_START_X    = 3'd4,
    CFG_START_Y    = 3'd5,
    CFG_LAYER_MODE = 3'd6
  } cfg_idx_e;

  // Config register file contents
  typedef struct packed {
    logic signed [REG_W-1:0] inc_xx;
    logic signed [REG_W-1:0] inc_xy;
    logic signed [REG_W-1:0] inc_yx;
    logic signed [REG_W-1:0] inc_yy;
    logic signed [REG_W-1:0] start_x;
    logic signed [REG_W-1:0] start_y;
    logic        [REG_W-1:0] layer_mode;
  } cfg_t;

  // Decoded mode
  typedef struct packed {
    logic nowrap;     // clip instead of wrap
    logic small_map;  // 256 map instead of full size
  } mode_t;

endpackage

@@ design/rzsa_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rzsa_cfg_regs: configuration register file
// Holds the matrix, start point and mode word, and decodes the mode word.
// ----------------------------------------------------------------------------
module rzsa_cfg_regs import rzsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0] cfg_data_i,
  output cfg_t             cfg_o,
  output mode_t            mode_o
);

  cfg_t cfg_d, cfg_q;

  // Register write decode; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INC_XX:     cfg_d.inc_xx     = cfg_data_i;
        CFG_INC_XY:     cfg_d.inc_xy     = cfg_data_i;
        CFG_INC_YX:     cfg_d.inc_yx     = cfg_data_i;
        CFG_INC_YY:     cfg_d.inc_yy     = cfg_data_i;
        CFG_START_X:    cfg_d.start_x    = cfg_data_i;
        CFG_START_Y:    cfg_d.start_y    = cfg_data_i;
        CFG_LAYER_MODE: cfg_d.layer_mode = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{inc_xx: '0, inc_xy: '0, inc_yx: '0, inc_yy: '0,
                 start_x: '0, start_y: '0, layer_mode: MODE_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Mode word decode; unknown words wrap at full size
  always_comb begin
    mode_o.nowrap    = (cfg_q.layer_mode == MODE_NOWRAP_A) ||
                       (cfg_q.layer_mode == MODE_NOWRAP_B) ||
                       (cfg_q.layer_mode == MODE_NOWRAP_SMALL);
    mode_o.small_map = (cfg_q.layer_mode == MODE_NOWRAP_SMALL);
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/rzsa_axis.sv @@
// ----------------------------------------------------------------------------
// rzsa_axis: one axis of the affine transform
// Two registered products, then the sum with the start point and the
// coordinate slice. Used once for x and once for y.
// ----------------------------------------------------------------------------
module rzsa_axis import rzsa_pkg::*; #(
  parameter int DEST_COORD_BITS = DEST_COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [DEST_COORD_BITS:0]   col_i,
  input  logic [DEST_COORD_BITS-1:0] row_i,
  input  logic signed [REG_W-1:0]    inc_col_i,
  input  logic signed [REG_W-1:0]    inc_row_i,
  input  logic signed [REG_W-1:0]    start_i,
  output logic [CRD_W-1:0]           coord_o
);

  // Product widths: unsigned operand plus a sign bit times 16 bit signed
  localparam int PcW = DEST_COORD_BITS + 2 + REG_W;
  localparam int PrW = DEST_COORD_BITS + 1 + REG_W;

  logic signed [PcW-1:0] prod_col_d, prod_col_q;
  logic signed [PrW-1:0] prod_row_d, prod_row_q;
  logic        [ACC_W-1:0] start_ext;
  logic        [ACC_W-1:0] acc;
  logic        [CRD_W-1:0] coord_q;

  // Multiply stage
  always_comb begin
    prod_col_d = PcW'($signed({1'b0, col_i})) * PcW'(inc_col_i);
    prod_row_d = PrW'($signed({1'b0, row_i})) * PrW'(inc_row_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_col_q <= prod_col_d;
      prod_row_q <= prod_row_d;
    end
  end

  // Sum stage; only the low 24 accumulator bits reach the coordinate
  always_comb begin
    start_ext = {{(ACC_W-REG_W-4){start_i[REG_W-1]}}, start_i, 4'b0000};
    acc       = prod_col_q[ACC_W-1:0] + prod_row_q[ACC_W-1:0] + start_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coord_q <= acc[CRD_LSB +: CRD_W];
    end
  end

  assign coord_o = coord_q;

endmodule

@@ design/rzsa_clip.sv @@
// ----------------------------------------------------------------------------
// rzsa_clip: map bound check and output register
// Masks the coordinates to the map size, flags out-of-range pixels when
// wrapping is off, and zeroes their coordinates.
// ----------------------------------------------------------------------------
module rzsa_clip import rzsa_pkg::*; #(
  parameter int MAP_SIZE = MAP_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [CRD_W-1:0] cx_i,
  input  logic [CRD_W-1:0] cy_i,
  input  mode_t            mode_i,
  output logic [SRC_W-1:0] src_x_o,
  output logic [SRC_W-1:0] src_y_o,
  output logic             in_range_o
);

  localparam logic [CRD_W-1:0] MapLimit   = CRD_W'(MAP_SIZE);
  localparam logic [CRD_W-1:0] SmallLimit = CRD_W'(SMALL_MAP_SIZE);

  logic [CRD_W-1:0] limit, mask;
  logic             ok;
  logic [SRC_W-1:0] src_x_d, src_y_d, src_x_q, src_y_q;
  logic             in_range_q;

  // Bound select, compare and mask
  always_comb begin
    limit = mode_i.small_map ? SmallLimit : MapLimit;
    mask  = limit - CRD_W'(1);
    ok    = !mode_i.nowrap || ((cx_i < limit) && (cy_i < limit));
    src_x_d = ok ? SRC_W'(cx_i & mask) : '0;
    src_y_d = ok ? SRC_W'(cy_i & mask) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      src_x_q    <= src_x_d;
      src_y_q    <= src_y_d;
      in_range_q <= ok;
    end
  end

  assign src_x_o    = src_x_q;
  assign src_y_o    = src_y_q;
  assign in_range_o = in_range_q;

endmodule

@@ design/rotozoom_source_address.sv @@
// ----------------------------------------------------------------------------
// rotozoom_source_address: rotate-zoom source address generator
// Maps a destination pixel to a source map coordinate through a 2x2 affine
// matrix and a start point, with wrap or clip at the map size.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o   | dest_x_i, dest_y_i
//   out     | output    | out_valid_o / out_ready_i | src_x_o, src_y_o,
//           |           |                           | in_range_o
//   cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// One word per cycle while the output is not stalled; an accepted word passes
// column add, multiply, accumulate and clip/output register to out_valid_o.
// The four stages advance together; a stalled output holds every stage, so
// in_ready_o is low only while the output word waits and out_ready_i is low.
// Reset clears the stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module rotozoom_source_address import rzsa_pkg::*; #(
  parameter int MAP_SIZE        = MAP_SIZE_DEF,
  parameter int DEST_COORD_BITS = DEST_COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [DEST_COORD_BITS-1:0] dest_x_i,
  input  logic [DEST_COORD_BITS-1:0] dest_y_i,
  // result words
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [SRC_W-1:0]           src_x_o,
  output logic [SRC_W-1:0]           src_y_o,
  output logic                       in_range_o,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [IDX_W-1:0]           cfg_idx_i,
  input  logic [REG_W-1:0]           cfg_data_i
);

  localparam logic [DEST_COORD_BITS:0] ColOffset = (DEST_COORD_BITS+1)'(COL_OFFSET);

  cfg_t  cfg;
  mode_t mode;

  logic en;
  logic v1_q, v2_q, v3_q, vo_q;
  logic [DEST_COORD_BITS:0]   col_q;
  logic [DEST_COORD_BITS-1:0] row_q;
  logic [CRD_W-1:0]           cx, cy;

  rzsa_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .mode_o     (mode)
  );

  // Whole pipe moves unless the output word is held
  assign en         = !vo_q || out_ready_i;
  assign in_ready_o = en;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // Input stage: column offset
  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q <= {1'b0, dest_x_i} + ColOffset;
      row_q <= dest_y_i;
    end
  end

  rzsa_axis #(.DEST_COORD_BITS(DEST_COORD_BITS)) u_axis_x (
    .clk_i     (clk_i),
    .en_i      (en),
    .col_i     (col_q),
    .row_i     (row_q),
    .inc_col_i (cfg.inc_xx),
    .inc_row_i (cfg.inc_yx),
    .start_i   (cfg.start_x),
    .coord_o   (cx)
  );

  rzsa_axis #(.DEST_COORD_BITS(DEST_COORD_BITS)) u_axis_y (
    .clk_i     (clk_i),
    .en_i      (en),
    .col_i     (col_q),
    .row_i     (row_q),
    .inc_col_i (cfg.inc_xy),
    .inc_row_i (cfg.inc_yy),
    .start_i   (cfg.start_y),
    .coord_o   (cy)
  );

  rzsa_clip #(.MAP_SIZE(MAP_SIZE)) u_clip (
    .clk_i      (clk_i),
    .en_i       (en),
    .cx_i       (cx),
    .cy_i       (cy),
    .mode_i     (mode),
    .src_x_o    (src_x_o),
    .src_y_o    (src_y_o),
    .in_range_o (in_range_o)
  );

  assign out_valid_o = vo_q;

  // Checks
  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted word did not enter the first stage");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (v1_q == $past(v1_q)) && (v3_q == $past(v3_q)))
    else $error("pipeline moved during an output stall");

  a_clip_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_range_o) |-> (src_x_o == '0) && (src_y_o == '0))
    else $error("out-of-range word carries a nonzero coordinate");

  a_wrap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mode.nowrap && $stable(mode) && $past(!mode.nowrap, 2)) |-> in_range_o)
    else $error("wrap mode flagged a word out of range");

  a_small_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode.small_map && $stable(mode)) |->
      (src_x_o < SRC_W'(SMALL_MAP_SIZE)) && (src_y_o < SRC_W'(SMALL_MAP_SIZE)))
    else $error("small map coordinate past 256");

endmodule
